@@ design/wpc_pkg.sv @@
// Shared constants, types and the arctangent table for the waypoint heading controller.
`timescale 1ns / 1ps
`default_nettype none

package wpc_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int CORDIC_STEPS  = 14;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int ITER_W        = (CORDIC_ITERS > 1) ? $clog2(CORDIC_ITERS) : 1;
    localparam int ADDR_W        = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    localparam int MODE_W     = 1;
    localparam int SLOT_W     = 4;
    localparam int COORD_W    = 16;
    localparam int HEAD_W     = 15;
    localparam int LIN_W      = 15;
    localparam int ANG_W      = 16;
    localparam int IDX_W      = 5;
    localparam int TOL_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CX_W   = 32;
    localparam int CZ_W   = 24;
    localparam int ERR_W  = 18;

    localparam logic signed [CZ_W-1:0]  PI_Q20     = CZ_W'(3294199);
    localparam logic signed [ERR_W-1:0] PI_Q12     = ERR_W'(12868);
    localparam logic signed [ERR_W-1:0] TWO_PI_Q12 = ERR_W'(25736);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORWARD_SPEED,
        CFG_TURN_RATE,
        CFG_REACH_RADIUS,
        CFG_HEADING_TOL,
        CFG_WAYPOINT_COUNT
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MUL_RADIUS,
        MUL_DX,
        MUL_DY
    } mul_sel_t;

    typedef enum logic [1:0] {
        OUT_LOAD,
        OUT_FINISH,
        OUT_REACH,
        OUT_STEER
    } out_kind_t;

    typedef struct packed {
        logic       capture;
        logic       diff_en;
        mul_sel_t   mul_sel;
        logic       rsq_en;
        logic       dist_ld;
        logic       dist_acc;
        logic       idx_inc;
        logic       cordic_init;
        logic       cordic_step;
        logic       bear_en;
        logic       wrap_en;
        logic       out_load;
        out_kind_t  out_kind;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic at_end;
        logic in_reach;
        logic cordic_last;
        logic err_ok;
    } status_t;

    // atan(2^-i) in Q.20
    function automatic logic signed [CZ_W-1:0] atan_q20(input logic [4:0] i);
        logic signed [CZ_W-1:0] v;
        unique case (i)
            5'd0:    v = CZ_W'(823550);
            5'd1:    v = CZ_W'(486170);
            5'd2:    v = CZ_W'(256879);
            5'd3:    v = CZ_W'(130396);
            5'd4:    v = CZ_W'(65451);
            5'd5:    v = CZ_W'(32757);
            5'd6:    v = CZ_W'(16383);
            5'd7:    v = CZ_W'(8192);
            5'd8:    v = CZ_W'(4096);
            5'd9:    v = CZ_W'(2048);
            5'd10:   v = CZ_W'(1024);
            5'd11:   v = CZ_W'(512);
            5'd12:   v = CZ_W'(256);
            5'd13:   v = CZ_W'(128);
            5'd14:   v = CZ_W'(64);
            5'd15:   v = CZ_W'(32);
            5'd16:   v = CZ_W'(16);
            5'd17:   v = CZ_W'(8);
            5'd18:   v = CZ_W'(4);
            5'd19:   v = CZ_W'(2);
            5'd20:   v = CZ_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/wpc_ctrl.sv @@
// Sequencing state machine for the waypoint heading controller.
`timescale 1ns / 1ps
`default_nettype none

module wpc_ctrl
    import wpc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQR,
        S_SQX,
        S_SQY,
        S_SUM,
        S_CMP,
        S_ITER,
        S_BEAR,
        S_WRAP,
        S_DONE
    } state_t;

    state_t    state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    out_kind_t kind_reg, kind_next;
    logic      out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul_sel    = MUL_RADIUS;
        cmd.out_kind   = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.is_tick)
                begin
                    kind_next  = OUT_LOAD;
                    state_next = S_DONE;
                end
                else if (status.at_end)
                begin
                    kind_next  = OUT_FINISH;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.diff_en = 1'b1;
                    state_next  = S_SQR;
                end
            end
            S_SQR:
            begin
                cmd.mul_sel = MUL_RADIUS;
                state_next  = S_SQX;
            end
            S_SQX:
            begin
                cmd.mul_sel = MUL_DX;
                cmd.rsq_en  = 1'b1;
                state_next  = S_SQY;
            end
            S_SQY:
            begin
                cmd.mul_sel = MUL_DY;
                cmd.dist_ld = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.dist_acc = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                if (status.in_reach)
                begin
                    cmd.idx_inc = 1'b1;
                    kind_next   = OUT_REACH;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.cordic_init = 1'b1;
                    state_next      = S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_last)
                begin
                    state_next = S_BEAR;
                end
            end
            S_BEAR:
            begin
                cmd.bear_en = 1'b1;
                state_next  = S_WRAP;
            end
            S_WRAP:
            begin
                if (status.err_ok)
                begin
                    kind_next  = OUT_STEER;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.wrap_en = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg      <= OUT_LOAD;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
        end
    end

endmodule

`default_nettype wire

@@ design/wpc_datapath.sv @@
// Datapath: waypoint table, settings, distance multiplier, CORDIC unit and result register.
`timescale 1ns / 1ps
`default_nettype none

module wpc_datapath
    import wpc_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cmd_t                        cmd,
    output status_t                          status,
    input  wire logic                        cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data,
    input  wire logic [MODE_W-1:0]           mode,
    input  wire logic [SLOT_W-1:0]           slot,
    input  wire logic signed [COORD_W-1:0]   waypoint_x,
    input  wire logic signed [COORD_W-1:0]   waypoint_y,
    input  wire logic signed [COORD_W-1:0]   pose_x,
    input  wire logic signed [COORD_W-1:0]   pose_y,
    input  wire logic signed [HEAD_W-1:0]    pose_heading,
    output logic [LIN_W-1:0]                 linear_cmd,
    output logic signed [ANG_W-1:0]          angular_cmd,
    output logic [IDX_W-1:0]                 target_index,
    output logic                             reached,
    output logic                             finished,
    output logic                             turning
);

    logic [LIN_W-1:0]  fwd_reg;
    logic [LIN_W-1:0]  turn_reg;
    logic [LIN_W-1:0]  reach_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [IDX_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic signed [COORD_W-1:0] tab_x_reg [MAX_WAYPOINTS];
    logic signed [COORD_W-1:0] tab_y_reg [MAX_WAYPOINTS];

    logic [MODE_W-1:0]         mode_reg;
    logic signed [COORD_W-1:0] pose_x_reg, pose_y_reg;
    logic signed [HEAD_W-1:0]  heading_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [PROD_W-1:0]         prod_reg, rsq_reg, dist_reg;
    logic signed [CX_W-1:0]    cx_reg, cy_reg;
    logic signed [CZ_W-1:0]    cz_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic                      zero_reg;
    logic signed [ERR_W-1:0]   err_reg;

    logic [LIN_W-1:0]          lin_reg;
    logic signed [ANG_W-1:0]   ang_reg;
    logic [IDX_W-1:0]          tidx_reg;
    logic                      reached_reg, finished_reg, turning_reg;

    logic [ADDR_W-1:0]         rd_addr;
    logic signed [COORD_W-1:0] tgt_x, tgt_y;
    logic signed [DIFF_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [CX_W-1:0]    x0, y0, xs, ys;
    logic signed [CZ_W-1:0]    atan_i;
    logic signed [CZ_W:0]      z_round;
    logic signed [ERR_W-1:0]   bear_ext, head_ext, tol_s;
    logic                      err_hi, err_lo, turn_cond;
    logic signed [ANG_W-1:0]   turn_s;

    assign rd_addr = ADDR_W'(idx_reg);
    assign tgt_x   = tab_x_reg[rd_addr];
    assign tgt_y   = tab_y_reg[rd_addr];

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            MUL_DY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            default:
            begin
                mul_a = $signed(DIFF_W'(reach_reg));
                mul_b = $signed(DIFF_W'(reach_reg));
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    assign x0     = CX_W'(dx_reg) <<< 12;
    assign y0     = CX_W'(dy_reg) <<< 12;
    assign xs     = cx_reg >>> iter_reg;
    assign ys     = cy_reg >>> iter_reg;
    assign atan_i = atan_q20(5'(iter_reg));

    assign z_round  = (CZ_W + 1)'(cz_reg) + (CZ_W + 1)'(128);
    assign bear_ext = zero_reg ? '0 : ERR_W'(z_round >>> 8);
    assign head_ext = ERR_W'(heading_reg);

    assign err_hi    = err_reg > PI_Q12;
    assign err_lo    = err_reg < -PI_Q12;
    assign tol_s     = $signed(ERR_W'(tol_reg));
    assign turn_cond = (err_reg > tol_s) || (err_reg < -tol_s);
    assign turn_s    = $signed(ANG_W'(turn_reg));

    assign status.is_tick     = mode_reg[0];
    assign status.at_end      = (32'(idx_reg) >= 32'(count_reg))
                                || (32'(idx_reg) >= MAX_WAYPOINTS);
    assign status.in_reach    = dist_reg < rsq_reg;
    assign status.cordic_last = (iter_reg == ITER_W'(CORDIC_ITERS - 1));
    assign status.err_ok      = !err_hi && !err_lo;

    // settings and waypoint index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= LIN_W'(77);
            turn_reg  <= LIN_W'(2048);
            reach_reg <= LIN_W'(77);
            tol_reg   <= TOL_W'(410);
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_FORWARD_SPEED:  fwd_reg   <= cfg_data[LIN_W-1:0];
                    CFG_TURN_RATE:      turn_reg  <= cfg_data[LIN_W-1:0];
                    CFG_REACH_RADIUS:   reach_reg <= cfg_data[LIN_W-1:0];
                    CFG_HEADING_TOL:    tol_reg   <= cfg_data[TOL_W-1:0];
                    CFG_WAYPOINT_COUNT: count_reg <= cfg_data[IDX_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && (mode == '0) && (32'(slot) < MAX_WAYPOINTS))
        begin
            tab_x_reg[ADDR_W'(slot)] <= waypoint_x;
            tab_y_reg[ADDR_W'(slot)] <= waypoint_y;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $unsigned(prod_full);
        if (cmd.capture)
        begin
            mode_reg    <= mode;
            pose_x_reg  <= pose_x;
            pose_y_reg  <= pose_y;
            heading_reg <= pose_heading;
        end
        if (cmd.diff_en)
        begin
            dx_reg <= DIFF_W'(tgt_x) - DIFF_W'(pose_x_reg);
            dy_reg <= DIFF_W'(tgt_y) - DIFF_W'(pose_y_reg);
        end
        if (cmd.rsq_en)
        begin
            rsq_reg <= prod_reg;
        end
        if (cmd.dist_ld)
        begin
            dist_reg <= prod_reg;
        end
        else if (cmd.dist_acc)
        begin
            dist_reg <= dist_reg + prod_reg;
        end
        if (cmd.cordic_init)
        begin
            iter_reg <= '0;
            zero_reg <= (dx_reg == '0) && (dy_reg == '0);
            if (dx_reg < 0)
            begin
                cx_reg <= -x0;
                cy_reg <= -y0;
                cz_reg <= (dy_reg >= 0) ? PI_Q20 : -PI_Q20;
            end
            else
            begin
                cx_reg <= x0;
                cy_reg <= y0;
                cz_reg <= '0;
            end
        end
        else if (cmd.cordic_step)
        begin
            iter_reg <= iter_reg + ITER_W'(1);
            if (cy_reg >= 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_i;
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_i;
            end
        end
        if (cmd.bear_en)
        begin
            err_reg <= bear_ext - head_ext;
        end
        else if (cmd.wrap_en)
        begin
            err_reg <= err_hi ? (err_reg - TWO_PI_Q12) : (err_reg + TWO_PI_Q12);
        end
        if (cmd.out_load)
        begin
            tidx_reg     <= idx_reg;
            lin_reg      <= '0;
            ang_reg      <= '0;
            reached_reg  <= 1'b0;
            finished_reg <= 1'b0;
            turning_reg  <= 1'b0;
            unique case (cmd.out_kind)
                OUT_FINISH: finished_reg <= 1'b1;
                OUT_REACH:  reached_reg  <= 1'b1;
                OUT_STEER:
                begin
                    if (turn_cond)
                    begin
                        turning_reg <= 1'b1;
                        ang_reg     <= (err_reg > 0) ? turn_s : -turn_s;
                    end
                    else
                    begin
                        lin_reg <= fwd_reg;
                        ang_reg <= ANG_W'(err_reg >>> 1);
                    end
                end
                default:    ;
            endcase
        end
    end

    assign linear_cmd   = lin_reg;
    assign angular_cmd  = ang_reg;
    assign target_index = tidx_reg;
    assign reached      = reached_reg;
    assign finished     = finished_reg;
    assign turning      = turning_reg;

endmodule

`default_nettype wire

@@ design/waypoint_heading_controller_unit.sv @@
// Top level of the turn-then-go waypoint heading controller.
`timescale 1ns / 1ps
`default_nettype none

// Every input transaction gives exactly one result transaction. A load
// (mode 0) writes a waypoint and answers; a tick either finds the route
// done, or reaches a waypoint once the squared distance is known, or
// steers. A steering tick runs the 14 steps of the iterative CORDIC atan2
// unit, one step a cycle, after a shared 17 x 17 multiplier has formed the
// squared distance, then forms the heading error and wraps it if needed.
// One item is in flight at a time; the result register lets the next item
// in while a result still waits. Settings are written over the cfg channel,
// which is always ready; the user must write them only while the block is
// idle, as the block itself does not enforce this.

module waypoint_heading_controller_unit
    import wpc_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [MODE_W-1:0]           mode,
    input  wire logic [SLOT_W-1:0]           slot,
    input  wire logic signed [COORD_W-1:0]   waypoint_x,
    input  wire logic signed [COORD_W-1:0]   waypoint_y,
    input  wire logic signed [COORD_W-1:0]   pose_x,
    input  wire logic signed [COORD_W-1:0]   pose_y,
    input  wire logic signed [HEAD_W-1:0]    pose_heading,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [LIN_W-1:0]                 linear_cmd,
    output logic signed [ANG_W-1:0]          angular_cmd,
    output logic [IDX_W-1:0]                 target_index,
    output logic                             reached,
    output logic                             finished,
    output logic                             turning
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    wpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    wpc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .slot         (slot),
        .waypoint_x   (waypoint_x),
        .waypoint_y   (waypoint_y),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .linear_cmd   (linear_cmd),
        .angular_cmd  (angular_cmd),
        .target_index (target_index),
        .reached      (reached),
        .finished     (finished),
        .turning      (turning)
    );

endmodule

`default_nettype wire

@@ design/wpc_checker.sv @@
// Port-level checks for the waypoint heading controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wpc_checker
    import wpc_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [LIN_W-1:0]           linear_cmd,
    input wire logic signed [ANG_W-1:0]    angular_cmd,
    input wire logic [IDX_W-1:0]           target_index,
    input wire logic                       reached,
    input wire logic                       finished,
    input wire logic                       turning
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(linear_cmd)
            && $stable(angular_cmd) && $stable(target_index) && $stable(turning))
        else $error("result changed while stalled");

    // one transaction in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_finish_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> linear_cmd == '0 && angular_cmd == '0
            && !turning && !reached)
        else $error("finished result is not a stop");

    a_turn_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && turning |-> linear_cmd == '0 && !reached && !finished)
        else $error("turn result carries forward motion or flags");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(target_index) <= MAX_WAYPOINTS)
        else $error("target index beyond table");

endmodule

bind waypoint_heading_controller_unit wpc_checker u_wpc_checker (.*);

`default_nettype wire

@@ verif/tb_waypoint_heading_controller_unit.sv @@
// Self-checking testbench for the waypoint heading controller: directed and random tests.
`timescale 1ns / 1ps

module tb_waypoint_heading_controller_unit
    import wpc_pkg::*;
();

    localparam logic   MODE_LOAD  = 1'b0;
    localparam logic   MODE_TICK  = 1'b1;
    localparam longint PI_Z       = 3294199;
    localparam longint HALF_TURN  = 12868;
    localparam longint FULL_TURN  = 25736;
    localparam int     RANDOM_ITEMS = 1500;

    localparam longint ATAN_Z [0:23] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0, 0, 0
    };

    typedef struct {
        logic                mode;
        logic [3:0]          slot;
        logic signed [15:0]  tx;
        logic signed [15:0]  ty;
        logic signed [15:0]  px;
        logic signed [15:0]  py;
        logic signed [14:0]  hd;
    } nav_item_t;

    typedef struct {
        logic [14:0]         lin;
        logic signed [15:0]  ang;
        logic [4:0]          idx;
        logic                reached;
        logic                finished;
        logic                turning;
    } steer_cmd_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [MODE_W-1:0]           mode;
    logic [SLOT_W-1:0]           slot;
    logic signed [COORD_W-1:0]   waypoint_x;
    logic signed [COORD_W-1:0]   waypoint_y;
    logic signed [COORD_W-1:0]   pose_x;
    logic signed [COORD_W-1:0]   pose_y;
    logic signed [HEAD_W-1:0]    pose_heading;
    logic                        out_valid;
    logic                        out_ready;
    logic [LIN_W-1:0]            linear_cmd;
    logic signed [ANG_W-1:0]     angular_cmd;
    logic [IDX_W-1:0]            target_index;
    logic                        reached;
    logic                        finished;
    logic                        turning;

    // predictor state
    longint      wp_x [0:15];
    longint      wp_y [0:15];
    int unsigned route_idx;
    longint      spd_q8, turn_q12, reach_q8, tol_q12;
    int unsigned route_len;

    steer_cmd_t  expected_cmds [$];
    int          mismatch_count;
    int          items_done;
    bit          quiet_in;
    bit          quiet_out;

    waypoint_heading_controller_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .slot         (slot),
        .waypoint_x   (waypoint_x),
        .waypoint_y   (waypoint_y),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .linear_cmd   (linear_cmd),
        .angular_cmd  (angular_cmd),
        .target_index (target_index),
        .reached      (reached),
        .finished     (finished),
        .turning      (turning)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int idle_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    // vectoring CORDIC, result in Q3.12
    function automatic longint cordic_bearing(longint dx, longint dy);
        longint x, y, z, xs, ys;
        int     i;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 4096;
        y = dy * 4096;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Z : -PI_Z;
            x = -x;
            y = -y;
        end
        for (i = 0; i < CORDIC_ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Z[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Z[i];
            end
        end
        return (z + 128) >>> 8;
    endfunction

    function automatic steer_cmd_t compute_command(nav_item_t it);
        steer_cmd_t  c;
        longint      dx, dy, err, ang;
        int unsigned eff;
        c = '{lin: '0, ang: '0, idx: '0, reached: 1'b0, finished: 1'b0, turning: 1'b0};
        if (it.mode == MODE_LOAD)
        begin
            wp_x[it.slot] = it.tx;
            wp_y[it.slot] = it.ty;
            c.idx = IDX_W'(route_idx);
            return c;
        end
        eff = (route_len > MAX_WAYPOINTS) ? MAX_WAYPOINTS : route_len;
        if (route_idx >= eff)
        begin
            c.finished = 1'b1;
            c.idx = IDX_W'(route_idx);
            return c;
        end
        dx = wp_x[route_idx] - it.px;
        dy = wp_y[route_idx] - it.py;
        if (dx * dx + dy * dy < reach_q8 * reach_q8)
        begin
            route_idx++;
            c.reached = 1'b1;
            c.idx = IDX_W'(route_idx);
            return c;
        end
        err = cordic_bearing(dx, dy) - it.hd;
        while (err > HALF_TURN)
            err = err - FULL_TURN;
        while (err < -HALF_TURN)
            err = err + FULL_TURN;
        if ((err < 0 ? -err : err) > tol_q12)
        begin
            c.turning = 1'b1;
            ang = (err > 0) ? turn_q12 : -turn_q12;
        end
        else
        begin
            c.lin = LIN_W'(spd_q8);
            ang = err >>> 1;
        end
        if (ang > 32767)
            ang = 32767;
        if (ang < -32768)
            ang = -32768;
        c.ang = ANG_W'(ang);
        c.idx = IDX_W'(route_idx);
        return c;
    endfunction

    function automatic nav_item_t load_item(int s, int x, int y);
        nav_item_t it;
        it.mode = MODE_LOAD;
        it.slot = SLOT_W'(s);
        it.tx = COORD_W'(x);
        it.ty = COORD_W'(y);
        it.px = COORD_W'($urandom);
        it.py = COORD_W'($urandom);
        it.hd = HEAD_W'(int'($urandom_range(0, 25736)) - 12868);
        return it;
    endfunction

    function automatic nav_item_t tick_item(int x, int y, int h);
        nav_item_t it;
        it.mode = MODE_TICK;
        it.slot = SLOT_W'($urandom);
        it.tx = COORD_W'($urandom);
        it.ty = COORD_W'($urandom);
        it.px = COORD_W'(x);
        it.py = COORD_W'(y);
        it.hd = HEAD_W'(h);
        return it;
    endfunction

    task automatic send_item(nav_item_t it);
        int gap;
        @(negedge clk);
        mode         = it.mode;
        slot         = it.slot;
        waypoint_x   = it.tx;
        waypoint_y   = it.ty;
        pose_x       = it.px;
        pose_y       = it.py;
        pose_heading = it.hd;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_cmds.insert(expected_cmds.size(), compute_command(it));
        gap = idle_len(quiet_in);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        wait_idle();
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FORWARD_SPEED:  spd_q8    = value & 'h7FFF;
            CFG_TURN_RATE:      turn_q12  = value & 'h7FFF;
            CFG_REACH_RADIUS:   reach_q8  = value & 'h7FFF;
            CFG_HEADING_TOL:    tol_q12   = value & 'h3FFF;
            CFG_WAYPOINT_COUNT: route_len = value & 'h1F;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic flag_field(string name, longint want, longint got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        steer_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cmds.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result transaction with none expected", $time);
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (linear_cmd !== want.lin)
                    flag_field("linear_cmd", want.lin, linear_cmd);
                if (angular_cmd !== want.ang)
                    flag_field("angular_cmd", want.ang, angular_cmd);
                if (target_index !== want.idx)
                    flag_field("target_index", want.idx, target_index);
                if (reached !== want.reached)
                    flag_field("reached", want.reached, reached);
                if (finished !== want.finished)
                    flag_field("finished", want.finished, finished);
                if (turning !== want.turning)
                    flag_field("turning", want.turning, turning);
            end
        end
    end

    // result-side back-pressure
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_ready = 1'b0;
                hold--;
            end
            else
            begin
                out_ready = 1'b1;
                hold = idle_len(quiet_out);
            end
        end
    end

    task automatic test_finished_at_reset();
        send_item(tick_item($urandom, $urandom, 0));
    endtask

    task automatic test_load_table();
        int s;
        send_item(load_item(0, 32767, -32768));
        send_item(load_item(1, -32768, 32767));
        for (s = 2; s < 16; s++)
            send_item(load_item(s, $urandom, $urandom));
    endtask

    task automatic test_reach_and_steer();
        write_reg(CFG_WAYPOINT_COUNT, 16);
        send_item(tick_item(32767, -32768, 0));
        send_item(tick_item(32767, -32768, -12868));
        send_item(tick_item(0, 32767, 12868));
        send_item(tick_item(0, 32767, -12868));
        send_item(tick_item(-30768, 32767, 0));
        send_item(tick_item(-32768, 29767, 6734));
    endtask

    task automatic test_zero_offset();
        write_reg(CFG_REACH_RADIUS, 0);
        send_item(tick_item(-32768, 32767, 0));
        send_item(tick_item(-32768, 32767, -301));
        send_item(tick_item(-32768, 32767, 12868));
        write_reg(CFG_REACH_RADIUS, 77);
    endtask

    task automatic test_route_length();
        write_reg(CFG_WAYPOINT_COUNT, 1);
        send_item(tick_item($urandom, $urandom, 0));
        write_reg(CFG_WAYPOINT_COUNT, 31);
        send_item(tick_item($urandom, $urandom, -100));
    endtask

    task automatic run_phase(int spd, int turn, int reach, int tol, int len, int n,
                             bit q_in, bit q_out);
        nav_item_t it;
        longint    tx, ty, b;
        int        ox, oy, q, sel, h, sw, k;
        int unsigned eff;
        write_reg(CFG_FORWARD_SPEED, spd);
        write_reg(CFG_TURN_RATE, turn);
        write_reg(CFG_REACH_RADIUS, reach);
        write_reg(CFG_HEADING_TOL, tol);
        write_reg(CFG_WAYPOINT_COUNT, len);
        quiet_in  = q_in;
        quiet_out = q_out;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 10)
                it = load_item($urandom_range(0, 15), $urandom, $urandom);
            else
            begin
                it  = tick_item(0, 0, 0);
                eff = (route_len > MAX_WAYPOINTS) ? MAX_WAYPOINTS : route_len;
                tx  = (route_idx < 16) ? wp_x[route_idx] : 0;
                ty  = (route_idx < 16) ? wp_y[route_idx] : 0;
                sel = $urandom_range(0, 99);
                // reaching is paced so the route lasts the whole run
                if (route_idx < eff && sel < 8 && route_idx * RANDOM_ITEMS < items_done * 16)
                begin
                    q  = reach * 3 / 4;
                    ox = int'($urandom_range(0, 2 * q)) - q;
                    oy = int'($urandom_range(0, 2 * q)) - q;
                end
                else if (sel < 55)
                begin
                    ox = reach + 1 + int'($urandom_range(0, 4000));
                    if ($urandom_range(0, 1))
                        ox = -ox;
                    oy = int'($urandom_range(0, 8000)) - 4000;
                    if ($urandom_range(0, 1))
                    begin
                        sw = ox;
                        ox = oy;
                        oy = sw;
                    end
                end
                else
                begin
                    ox = $urandom_range(0, 65535);
                    oy = $urandom_range(0, 65535);
                end
                it.px = COORD_W'(tx + ox);
                it.py = COORD_W'(ty + oy);
                sel = $urandom_range(0, 99);
                if (sel < 40)
                begin
                    b = cordic_bearing(tx - it.px, ty - it.py);
                    h = int'(b) + int'($urandom_range(0, 2 * (tol + 64))) - (tol + 64);
                    if (h > HALF_TURN)
                        h = h - FULL_TURN;
                    if (h < -HALF_TURN)
                        h = h + FULL_TURN;
                end
                else if (sel < 50)
                    case ($urandom_range(0, 2))
                        0:       h = -12868;
                        1:       h = 12868;
                        default: h = 0;
                    endcase
                else
                    h = int'($urandom_range(0, 25736)) - 12868;
                it.hd = HEAD_W'(h);
            end
            send_item(it);
            items_done++;
            if (k == n / 2)
                wait_idle();
        end
    endtask

    task automatic test_random_route();
        run_phase($urandom_range(1, 2000), $urandom_range(0, 32767), $urandom_range(20, 1500),
                  $urandom_range(0, 12868), 16, 300, 1'b0, 1'b0);
        run_phase(0, 0, 77, 0, 16, 200, 1'b1, 1'b1);
        run_phase(32767, 32767, $urandom_range(0, 800), 12868, 16, 200, 1'b0, 1'b1);
        run_phase($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 1500),
                  $urandom_range(0, 12868), 0, 100, 1'b1, 1'b0);
        run_phase($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 1500),
                  $urandom_range(0, 12868), 20, 250, 1'b0, 1'b0);
        run_phase($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 1500),
                  $urandom_range(0, 12868), 31, 250, 1'b0, 1'b0);
        run_phase($urandom_range(0, 32767), $urandom_range(0, 32767), 32767,
                  $urandom_range(0, 12868), 16, 150, 1'b0, 1'b0);
    endtask

    initial
    begin
        int s;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = '0;
        slot         = '0;
        waypoint_x   = '0;
        waypoint_y   = '0;
        pose_x       = '0;
        pose_y       = '0;
        pose_heading = '0;
        quiet_in     = 1'b0;
        quiet_out    = 1'b0;
        mismatch_count = 0;
        items_done   = 0;
        for (s = 0; s < 16; s++)
        begin
            wp_x[s] = 0;
            wp_y[s] = 0;
        end
        route_idx = 0;
        spd_q8    = 77;
        turn_q12  = 2048;
        reach_q8  = 77;
        tol_q12   = 410;
        route_len = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_finished_at_reset();
        test_load_table();
        test_reach_and_steer();
        test_zero_offset();
        test_route_length();
        test_random_route();

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_cmds.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
